>>> rtl/core/spq_pkg.sv
// Shared constants and types for the sorted key priority queue.
// No dependencies; imported by the top level, the cells and the bench.
package spq_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int MAX_OUT    = 16;

	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int SENT_BITS = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

	localparam logic [1:0] CMD_ENQ   = 2'd0;
	localparam logic [1:0] CMD_DEQ   = 2'd1;
	localparam logic [1:0] CMD_RANGE = 2'd2;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic ins;	// insert new entry at its sorted place
		logic upd;	// overwrite value of the matching entry
		logic deq;	// shift every entry one cell toward the head
	} spq_ctrl_t;

	typedef logic [KEY_BITS-1:0]   spq_key_t;
	typedef logic [VALUE_BITS-1:0] spq_value_t;

endpackage

>>> rtl/core/sorted_key_priority_queue.sv
// Top level of the sorted key priority queue: command sequencer and cell chain.
// Depends on spq_pkg and spq_cell.
//
// A command is taken when start is high and busy is low. Each result appears on
// ok/out_key/out_value/last for exactly one cycle with strobe high; the receiver
// cannot stall it, so it must take every strobe. Enqueue and dequeue first
// register the command, then all cells compare against the key in parallel and
// shift or load together. The result strobes in the following cycle, during
// which the next command may already be accepted. A range query builds a match
// vector from every cell in the same way, then streams one matching entry per
// cycle, lowest key first; when nothing matches, a single failure result is
// given. Command code 3 is dropped with no result. No clearing pass is needed
// after reset: a cell counts as occupied only when its index is below the entry
// count.
module sorted_key_priority_queue import spq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic [31:0] range_end,
	output logic        strobe,
	output logic        ok,
	output logic [31:0] out_key,
	output logic [31:0] out_value,
	output logic        last
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_STREAM = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_BITS-1:0] count_q;
	logic [1:0]          cmd_q;
	spq_key_t            key_q;
	spq_key_t            hi_q;
	spq_value_t          value_q;
	logic [CAPACITY-1:0] match_q;
	logic [SENT_BITS-1:0] sent_q;

	logic                strobe_q;
	logic                ok_q;
	logic                last_q;
	logic [31:0]         out_key_q;
	logic [31:0]         out_value_q;

	spq_ctrl_t           ctrl;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] hit;
	spq_key_t            cell_key   [CAPACITY];
	spq_value_t          cell_value [CAPACITY];

	logic                accept;
	logic                exec;
	logic                found;
	logic                full;
	logic [IDX_BITS-1:0] pick;
	logic [CAPACITY-1:0] match_rest;
	logic                pick_last;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign exec      = (state_q == ST_EXEC);
	assign found     = |eq;
	assign full      = (count_q == CNT_BITS'(CAPACITY));

	assign strobe    = strobe_q;
	assign ok        = ok_q;
	assign last      = last_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;

	// Cell control: broadcast for one cycle while the command executes.
	always_comb begin
		ctrl.upd = exec && (cmd_q == CMD_ENQ) && found;
		ctrl.ins = exec && (cmd_q == CMD_ENQ) && !found && !full;
		ctrl.deq = exec && (cmd_q == CMD_DEQ) && (count_q != '0);
	end

	// Chain of cells; cell 0 holds the smallest key.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_BITS'(i) < count_q);

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.ref_key     (key_q),
				.hi_key      (hi_q),
				.new_value   (value_q),
				.left_lt     (1'b1),
				.left_key    (key_q),
				.left_value  (value_q),
				.right_key   (cell_key[i+1]),
				.right_value (cell_value[i+1]),
				.cur_key     (cell_key[i]),
				.cur_value   (cell_value[i]),
				.lt          (lt[i]),
				.eq          (eq[i]),
				.hit         (hit[i])
			);
		end else if (i == CAPACITY - 1) begin : g_tail
			// tail refills from itself on dequeue; its slot is then unoccupied
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.ref_key     (key_q),
				.hi_key      (hi_q),
				.new_value   (value_q),
				.left_lt     (lt[i-1]),
				.left_key    (cell_key[i-1]),
				.left_value  (cell_value[i-1]),
				.right_key   (cell_key[i]),
				.right_value (cell_value[i]),
				.cur_key     (cell_key[i]),
				.cur_value   (cell_value[i]),
				.lt          (lt[i]),
				.eq          (eq[i]),
				.hit         (hit[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.ref_key     (key_q),
				.hi_key      (hi_q),
				.new_value   (value_q),
				.left_lt     (lt[i-1]),
				.left_key    (cell_key[i-1]),
				.left_value  (cell_value[i-1]),
				.right_key   (cell_key[i+1]),
				.right_value (cell_value[i+1]),
				.cur_key     (cell_key[i]),
				.cur_value   (cell_value[i]),
				.lt          (lt[i]),
				.eq          (eq[i]),
				.hit         (hit[i])
			);
		end
	end

	// Pick the lowest pending match; scan from the top so the lowest index wins.
	always_comb begin
		pick = '0;
		for (int j = CAPACITY - 1; j >= 0; j--) begin
			if (match_q[j]) begin
				pick = IDX_BITS'(j);
			end
		end
		match_rest       = match_q;
		match_rest[pick] = 1'b0;
		pick_last        = (match_rest == '0) || (sent_q == SENT_BITS'(MAX_OUT - 1));
	end

	// Command capture: payload only, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			key_q   <= KEY_BITS'(key);
			hi_q    <= KEY_BITS'(range_end);
			value_q <= VALUE_BITS'(value);
		end
	end

	// Result payload: load alongside the strobe.
	always_ff @(posedge clk) begin
		if (exec) begin
			case (cmd_q)
				CMD_ENQ: begin
					ok_q        <= found || !full;
					out_key_q   <= (found || !full) ? 32'(key_q) : '0;
					out_value_q <= (found || !full) ? 32'(value_q) : '0;
					last_q      <= 1'b1;
				end
				CMD_DEQ: begin
					ok_q        <= (count_q != '0);
					out_key_q   <= (count_q != '0) ? 32'(cell_key[0]) : '0;
					out_value_q <= (count_q != '0) ? 32'(cell_value[0]) : '0;
					last_q      <= 1'b1;
				end
				default: begin
					// range failure when nothing matches; otherwise overwritten by stream
					ok_q        <= 1'b0;
					out_key_q   <= '0;
					out_value_q <= '0;
					last_q      <= 1'b1;
				end
			endcase
		end else if (state_q == ST_STREAM) begin
			ok_q        <= 1'b1;
			out_key_q   <= 32'(cell_key[pick]);
			out_value_q <= 32'(cell_value[pick]);
			last_q      <= pick_last;
		end
	end

	// Sequencer, entry count and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			match_q  <= '0;
			sent_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ctrl.ins) begin
						count_q <= count_q + 1'b1;
					end else if (ctrl.deq) begin
						count_q <= count_q - 1'b1;
					end
					if (cmd_q == CMD_RANGE && hit != '0) begin
						// hold the match vector and stream it
						match_q <= hit;
						sent_q  <= '0;
						state_q <= ST_STREAM;
					end else begin
						// give the single result, or drop an unused command code silently
						strobe_q <= (cmd_q == CMD_ENQ) || (cmd_q == CMD_DEQ) ||
							(cmd_q == CMD_RANGE);
						state_q  <= ST_IDLE;
					end
				end
				ST_STREAM: begin
					strobe_q <= 1'b1;
					match_q  <= match_rest;
					sent_q   <= sent_q + 1'b1;
					if (pick_last) begin
						match_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/spq_cell.sv
// One storage cell of the sorted chain: a key/value pair and its comparators.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_ctrl_t  ctrl,
	input  logic       occ,
	input  spq_key_t   ref_key,
	input  spq_key_t   hi_key,
	input  spq_value_t new_value,
	input  logic       left_lt,
	input  spq_key_t   left_key,
	input  spq_value_t left_value,
	input  spq_key_t   right_key,
	input  spq_value_t right_value,
	output spq_key_t   cur_key,
	output spq_value_t cur_value,
	output logic       lt,
	output logic       eq,
	output logic       hit
);

	spq_key_t   key_q;
	spq_value_t value_q;

	assign cur_key   = key_q;
	assign cur_value = value_q;

	assign lt  = occ && (key_q < ref_key);
	assign eq  = occ && (key_q == ref_key);
	assign hit = occ && (key_q >= ref_key) && (key_q <= hi_key);

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (ctrl.upd) begin
			if (eq) begin
				value_q <= new_value;
			end
		end else if (ctrl.ins && !lt) begin
			// first cell not below the key takes it, the rest move up one
			if (left_lt) begin
				key_q   <= ref_key;
				value_q <= new_value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end
	end

endmodule

>>> rtl/core/spq_checker.sv
// Port-level checks for the sorted key priority queue, bound to the top level.
// Depends on spq_pkg only through the bound module.
module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic        ok,
	input logic [31:0] out_key,
	input logic [31:0] out_value,
	input logic        last
);

	// an accepted command always occupies the block for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("accepted transfer did not raise busy");

	// the final result of a command releases the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on final result");

	// a result that is not final keeps the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("block idle with results still pending");

	// a failure is always a single, zeroed result
	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !ok |-> last && out_key == 32'd0 && out_value == 32'd0)
		else $error("malformed failure result");

endmodule

bind sorted_key_priority_queue spq_checker u_spq_checker (.*);

>>> bench/spq_bench_pkg.sv
// Scoreboard for the sorted key priority queue bench: a software copy of the sorted
// store that predicts every result, and the in-order checker for those results.
// Depends on spq_pkg for the widths, the capacity, the burst limit and the command codes.
package spq_bench_pkg;
	import spq_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		spq_key_t   k;
		spq_value_t v;
	} stored_entry_t;

	typedef struct {
		logic        ok;
		logic [31:0] k;
		logic [31:0] v;
		logic        last;
	} queue_result_t;

	class queue_model;
		stored_entry_t store[$];
		queue_result_t awaited[$];
		int unsigned issued[4] = '{0, 0, 0, 0};
		int unsigned mismatches = 0;
		int unsigned checked = 0;
		int unsigned full_rejects = 0;
		int unsigned empty_rejects = 0;
		int unsigned range_misses = 0;
		int unsigned max_burst = 0;

		// A failed result carries zero key and value.
		function void await_result(logic ok, spq_key_t k, spq_value_t v, logic last);
			queue_result_t r;
			r.ok = ok;
			r.k = ok ? 32'(k) : 32'd0;
			r.v = ok ? 32'(v) : 32'd0;
			r.last = last;
			awaited.push_back(r);
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_command(logic [1:0] op, logic [31:0] key_in,
			logic [31:0] value_in, logic [31:0] end_in);
			spq_key_t      lo;
			spq_key_t      hi;
			spq_value_t    val;
			stored_entry_t hit;
			queue_result_t tail;
			int            pos;
			int unsigned   hits;
			lo = spq_key_t'(key_in);
			hi = spq_key_t'(end_in);
			val = spq_value_t'(value_in);
			issued[op]++;
			case (op)
			CMD_ENQ: begin
				pos = 0;
				while (pos < store.size() && store[pos].k < lo)
					pos++;
				if (pos < store.size() && store[pos].k == lo) begin
					// Key present: update in place, even when full.
					hit = store[pos];
					hit.v = val;
					store[pos] = hit;
					await_result(1'b1, lo, val, 1'b1);
				end else if (store.size() >= CAPACITY) begin
					full_rejects++;
					await_result(1'b0, '0, '0, 1'b1);
				end else begin
					hit.k = lo;
					hit.v = val;
					store.insert(pos, hit);
					await_result(1'b1, lo, val, 1'b1);
				end
			end
			CMD_DEQ: begin
				if (store.size() == 0) begin
					empty_rejects++;
					await_result(1'b0, '0, '0, 1'b1);
				end else begin
					hit = store.pop_front();
					await_result(1'b1, hit.k, hit.v, 1'b1);
				end
			end
			CMD_RANGE: begin
				hits = 0;
				foreach (store[i])
					if (hits < MAX_OUT && store[i].k >= lo && store[i].k <= hi) begin
						await_result(1'b1, store[i].k, store[i].v, 1'b0);
						hits++;
					end
				if (hits == 0) begin
					range_misses++;
					await_result(1'b0, '0, '0, 1'b1);
				end else begin
					tail = awaited[awaited.size() - 1];
					tail.last = 1'b1;
					awaited[awaited.size() - 1] = tail;
					if (hits > max_burst)
						max_burst = hits;
				end
			end
			default: ;
			endcase
		endfunction

		function void check_result(logic ok, logic [31:0] k, logic [31:0] v, logic last);
			queue_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d unexpected: ok=%0b key=%h value=%h last=%0b",
						checked, ok, k, v, last);
				return;
			end
			want = awaited.pop_front();
			if (want.ok !== ok || want.k !== k || want.v !== v || want.last !== last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("result %0d wrong", checked);
					$display("  expected ok=%0b key=%h value=%h last=%0b",
						want.ok, want.k, want.v, want.last);
					$display("  actual   ok=%0b key=%h value=%h last=%0b", ok, k, v, last);
				end
			end
		endfunction
	endclass

endpackage

>>> bench/sorted_key_priority_queue_tb.sv
// Bench top for the sorted key priority queue: drives commands, watches the result
// strobe and hands both sides to the scoreboard in spq_bench_pkg.
// Depends on spq_pkg, spq_bench_pkg and the RTL top sorted_key_priority_queue.
module sorted_key_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;
	import spq_bench_pkg::*;

	// Longest stretch without any transfer before the run is declared hung. A correct
	// run stays far below this, even through the longest range burst and the sender
	// gaps at 83 percent idling.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS = 66;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = CMD_ENQ;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic [31:0] range_end = '0;
	logic        strobe;
	logic        ok;
	logic [31:0] out_key;
	logic [31:0] out_value;
	logic        last;

	queue_model  prio_model = new();
	int unsigned idle_pct = 0;
	int          quiet_cycles = 0;

	sorted_key_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.key       (key),
		.value     (value),
		.range_end (range_end),
		.strobe    (strobe),
		.ok        (ok),
		.out_key   (out_key),
		.out_value (out_value),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Take every strobed result at the edge that ends its cycle; the block cannot
	// be held off, so there is nothing to drive on this side.
	always @(posedge clk) begin
		if (arst_n && strobe)
			prio_model.check_result(ok, out_key, out_value, last);
	end

	// Count cycles with neither a command transfer nor a result; restart on either.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Present one command from a falling edge and hold it until the block takes it.
	// Before presenting, idle the sender cycle by cycle at the current rate.
	// Return on the falling edge after the transfer, with start still high, so a
	// back-to-back command only changes the fields.
	task automatic issue(logic [1:0] op, logic [31:0] k, logic [31:0] v,
		logic [31:0] hi);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = op;
		key = k;
		value = v;
		range_end = hi;
		do begin
			@(posedge clk);
		end while (busy);
		prio_model.note_command(op, k, v, hi);
		@(negedge clk);
	endtask

	// Drop start and hold off until every predicted result has come back.
	task automatic drain();
		start = 1'b0;
		while (prio_model.pending() != 0)
			@(negedge clk);
	endtask

	// Keys cluster at both ends of the range so that updates, duplicate keys and
	// the top bits all show up, with some fully random keys mixed in.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
		0, 1: return 32'($urandom_range(31));
		2: return 32'hFFFF_FFE0 | 32'($urandom_range(31));
		default: return $urandom();
		endcase
	endfunction

	// Mostly legal traffic with random content. The enqueue share swings every 40
	// commands so the store fills up, sits at capacity, and drains again.
	task automatic random_items(int unsigned count);
		int unsigned done_items;
		int unsigned roll;
		int unsigned enq_share;
		logic [31:0] lo;
		logic [31:0] hi;
		done_items = 0;
		while (done_items < count) begin
			enq_share = ((done_items / 40) % 2 == 0) ? 60 : 25;
			roll = $urandom_range(99);
			lo = pick_key();
			if (roll < 3) begin
				// Unused code: no result and no count toward the total.
				issue(CMD_UNUSED, $urandom(), $urandom(), $urandom());
				continue;
			end
			if (roll < 3 + enq_share)
				issue(CMD_ENQ, lo, $urandom(), $urandom());
			else if (roll < 18 + enq_share) begin
				case ($urandom_range(5))
				0: hi = $urandom();
				1: hi = (lo == 0) ? 32'd0 : lo - 32'd1;	// bounds crossed
				default: hi = (lo > 32'hFFFF_FFD7) ? 32'hFFFF_FFFF
					: lo + 32'($urandom_range(40));
				endcase
				issue(CMD_RANGE, lo, $urandom(), hi);
			end else
				issue(CMD_DEQ, lo, $urandom(), $urandom());
			done_items++;
		end
	endtask

	initial begin
		// Single reset at the start of the run; release on a falling edge.
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, no idling.
		// Dequeue and range on an empty store must both fail.
		issue(CMD_DEQ, 32'd0, 32'd0, 32'd0);
		issue(CMD_RANGE, 32'd0, 32'd0, 32'hFFFF_FFFF);
		// Extreme keys and values, then an update of an existing key.
		issue(CMD_ENQ, 32'hFFFF_FFFF, 32'd0, 32'd0);
		issue(CMD_ENQ, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(CMD_ENQ, 32'd0, 32'h1234_5678, 32'd0);
		// Crossed bounds give one failure; a one-key range hits the top entry.
		issue(CMD_RANGE, 32'd10, 32'd0, 32'd5);
		issue(CMD_RANGE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		// Unused code changes nothing.
		issue(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Fill to capacity with descending keys so each insert lands near the head.
		for (int i = 0; i < CAPACITY - 2; i++)
			issue(CMD_ENQ, 32'h8000_0000 - 32'(i) * 32'h0111_1111, $urandom(), 32'd0);
		// Full store: a new key is refused, an existing key is still updated.
		issue(CMD_ENQ, 32'd1, 32'hDEAD_BEEF, 32'd0);
		issue(CMD_ENQ, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'd0);
		// Full-span range streams every entry, the longest burst possible.
		issue(CMD_RANGE, 32'd0, 32'd0, 32'hFFFF_FFFF);
		issue(CMD_DEQ, 32'd0, 32'd0, 32'd0);
		drain();

		// Random part in three idling phases, draining between them.
		idle_pct = 12;
		random_items(PHASE_ITEMS);
		drain();
		idle_pct = 83;
		random_items(PHASE_ITEMS);
		drain();
		idle_pct = 0;
		random_items(PHASE_ITEMS);

		// Wait out anything still in flight, then allow for stray results.
		drain();
		repeat (20) @(posedge clk);

		$display("commands: %0d enqueue, %0d dequeue, %0d range, %0d unused; %0d results",
			prio_model.issued[CMD_ENQ], prio_model.issued[CMD_DEQ],
			prio_model.issued[CMD_RANGE], prio_model.issued[CMD_UNUSED],
			prio_model.checked);
		$display("refusals: %0d full, %0d empty, %0d empty range; longest burst %0d",
			prio_model.full_rejects, prio_model.empty_rejects,
			prio_model.range_misses, prio_model.max_burst);
		if (prio_model.mismatches == 0 && prio_model.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
